// ===== hdl/rbd_pkg.sv =====
// shared types, constants and codes of the planar byterun1 row decoder
// no dependencies; imported by every other file of the block
package rbd_pkg;

	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 13;
	localparam int QUEUE_DEPTH = 4;

	localparam int DEF_MAX_ROW_BYTES = 512;
	localparam int DEF_MAX_PLANES    = 8;
	localparam int DEF_MAX_ROWS      = 4096;

	// control byte that does nothing, and the rounding added to the width
	localparam logic [7:0] RUN_NOP     = 8'h80;
	localparam int         WIDTH_ROUND = 15;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE   = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2,
		REG_PLANES = 2'd3
	} reg_idx_t;

	typedef enum logic [7:0] {
		MODE_RAW  = 8'd0,
		MODE_RUN1 = 8'd1
	} mode_t;

	typedef enum logic [1:0] {
		PH_CONTROL = 2'd0,
		PH_LITERAL = 2'd1,
		PH_REPEAT  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		FIN_RUNNING = 2'd0,
		FIN_DONE    = 2'd1,
		FIN_ERROR   = 2'd2
	} fin_t;

	typedef enum logic [2:0] {
		ST_BUSY      = 3'd0,
		ST_COMPLETE  = 3'd1,
		ST_TRUNCATED = 3'd2,
		ST_OVERFLOW  = 3'd3,
		ST_BADMODE   = 3'd4,
		ST_IGNORED   = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0] body_byte;
		logic       last_byte;
	} body_t;

	typedef struct packed {
		logic       write_valid;
		logic [7:0] byte_value;
		logic [7:0] run_length;
		logic [2:0] plane_index;
		logic [11:0] row_index;
		logic [8:0] column_byte;
		logic [2:0] status;
	} result_t;

	// byte as classified by the front part
	typedef struct packed {
		logic [7:0] body_byte;
		logic       last_byte;
		logic       is_nop;
		logic       is_literal;
		logic [7:0] run_n;
	} cls_t;

	typedef struct packed {
		logic [7:0]  mode;
		logic [12:0] width;
		logic [12:0] height;
		logic [3:0]  planes;
	} cfg_t;

endpackage

// ===== hdl/rbd_body_if.sv =====
// input channel: one body byte per transfer
// depends on rbd_pkg
interface rbd_body_if;
	import rbd_pkg::*;
	logic  valid;
	logic  ready;
	body_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/rbd_result_if.sv =====
// output channel: one decode result per transfer
// depends on rbd_pkg
interface rbd_result_if;
	import rbd_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/rbd_front.sv =====
// front part: takes body bytes and classifies them as control codes
// depends on rbd_pkg, rbd_body_if
module rbd_front (
	input  logic           clk,
	input  logic           arst_n,
	rbd_body_if.sink       body,
	output logic           cls_valid,
	output rbd_pkg::cls_t  cls,
	input  logic           cls_ready
);
	import rbd_pkg::*;

	logic valid_s1;
	cls_t cls_s1;
	cls_t cls_d;
	logic [8:0] n_wide;

	always_comb begin
		if (body.data.body_byte[7]) begin
			n_wide = 9'd257 - {1'b0, body.data.body_byte};
		end else begin
			n_wide = {1'b0, body.data.body_byte} + 9'd1;
		end
		cls_d.body_byte  = body.data.body_byte;
		cls_d.last_byte  = body.data.last_byte;
		cls_d.is_nop     = (body.data.body_byte == RUN_NOP);
		cls_d.is_literal = !body.data.body_byte[7];
		cls_d.run_n      = n_wide[7:0];
	end

	assign body.ready = !valid_s1 || cls_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (body.ready) begin
			valid_s1 <= body.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (body.ready && body.valid) begin
			cls_s1 <= cls_d;
		end
	end

	assign cls_valid = valid_s1;
	assign cls       = cls_s1;

endmodule

// ===== hdl/rbd_queue.sv =====
// short queue between the classifying front and the decoding back
// depends on rbd_pkg
module rbd_queue #(
	parameter int DEPTH = rbd_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	input  rbd_pkg::cls_t push_data,
	output logic          push_ready,
	output logic          pop_valid,
	output rbd_pkg::cls_t pop_data,
	input  logic          pop_ready
);
	import rbd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cls_t          entry_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= push_data;
		end
	end

endmodule

// ===== hdl/rbd_back.sv =====
// back part: run decoding, row/plane/column tracking and the output register
// depends on rbd_pkg, rbd_result_if
module rbd_back #(
	parameter int MAX_ROW_BYTES = rbd_pkg::DEF_MAX_ROW_BYTES,
	parameter int MAX_PLANES    = rbd_pkg::DEF_MAX_PLANES,
	parameter int MAX_ROWS      = rbd_pkg::DEF_MAX_ROWS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  rbd_pkg::cfg_t cfg,
	input  logic          cls_valid,
	input  rbd_pkg::cls_t cls,
	output logic          cls_ready,
	rbd_result_if.source  result
);
	import rbd_pkg::*;

	localparam int COLW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
	localparam int PLW  = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
	localparam int ROWW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int RBW  = $clog2(MAX_ROW_BYTES + 1);
	localparam int RUW  = $clog2(MAX_ROWS + 1);
	// common width for position compares
	localparam int SUMW = ((RBW > 9) ? RBW : 9) + 1;
	localparam int ROWCW = RUW + 1;

	phase_t          phase_q, phase_d;
	logic [7:0]      lit_q, lit_d;
	logic [7:0]      rep_q, rep_d;
	logic [COLW-1:0] col_q, col_d;
	logic [PLW-1:0]  plane_q, plane_d;
	logic [ROWW-1:0] row_q, row_d;
	fin_t            fin_q, fin_d;

	logic            out_valid_q;
	result_t         out_q;
	result_t         res;

	logic [13:0]     rb_raw;
	logic [RBW-1:0]  rb;
	logic [3:0]      pu;
	logic [RUW-1:0]  ru;
	logic [SUMW-1:0] col_sum;
	logic [SUMW-1:0] room;
	logic [4:0]      plane_inc;
	logic [ROWCW-1:0] row_inc;
	logic            emit;
	logic [7:0]      emit_cnt;
	logic            done;
	logic [2:0]      status;
	logic            take;

	// saturated row length, plane count and height
	always_comb begin
		rb_raw = (((14'(cfg.width) + 14'(WIDTH_ROUND)) >> 4) << 1);
		if (rb_raw < 14'd2) begin
			rb = RBW'(2);
		end else if (32'(rb_raw) > MAX_ROW_BYTES) begin
			rb = RBW'(MAX_ROW_BYTES);
		end else begin
			rb = RBW'(rb_raw);
		end
		if (cfg.planes == 4'd0) begin
			pu = 4'd1;
		end else if (32'(cfg.planes) > MAX_PLANES) begin
			pu = 4'(MAX_PLANES);
		end else begin
			pu = cfg.planes;
		end
		if (cfg.height == 13'd0) begin
			ru = RUW'(1);
		end else if (32'(cfg.height) > MAX_ROWS) begin
			ru = RUW'(MAX_ROWS);
		end else begin
			ru = RUW'(cfg.height);
		end
	end

	assign take      = cls_valid && cls_ready;
	assign cls_ready = !out_valid_q || result.ready;

	always_comb begin
		phase_d  = phase_q;
		lit_d    = lit_q;
		rep_d    = rep_q;
		col_d    = col_q;
		plane_d  = plane_q;
		row_d    = row_q;
		fin_d    = fin_q;
		status   = 3'(ST_BUSY);
		emit     = 1'b0;
		emit_cnt = 8'd1;
		done     = 1'b0;
		room     = (SUMW'(col_q) < SUMW'(rb)) ? SUMW'(rb) - SUMW'(col_q) : '0;

		if (fin_q != FIN_RUNNING) begin
			status = 3'(ST_IGNORED);
		end else if (cfg.mode > MODE_RUN1) begin
			fin_d  = FIN_ERROR;
			status = 3'(ST_BADMODE);
		end else if (cfg.mode == MODE_RAW) begin
			emit = 1'b1;
		end else begin
			unique case (phase_q)
				PH_LITERAL: begin
					lit_d = (lit_q == 8'd0) ? 8'd0 : lit_q - 8'd1;
					if (lit_d == 8'd0) begin
						phase_d = PH_CONTROL;
					end
					emit = 1'b1;
				end
				PH_REPEAT: begin
					emit_cnt = rep_q;
					phase_d  = PH_CONTROL;
					rep_d    = 8'd0;
					emit     = 1'b1;
				end
				default: begin
					if (!cls.is_nop) begin
						if (SUMW'(cls.run_n) > room) begin
							fin_d  = FIN_ERROR;
							status = 3'(ST_OVERFLOW);
						end else if (cls.is_literal) begin
							lit_d   = cls.run_n;
							phase_d = PH_LITERAL;
						end else begin
							rep_d   = cls.run_n;
							phase_d = PH_REPEAT;
						end
					end
				end
			endcase
		end

		// advance column, then plane, then row
		col_sum   = SUMW'(col_q) + SUMW'(emit_cnt);
		plane_inc = 5'(plane_q) + 5'd1;
		row_inc   = ROWCW'(row_q) + ROWCW'(1);
		if (emit) begin
			if (col_sum >= SUMW'(rb)) begin
				col_d = '0;
				if (plane_inc >= 5'(pu)) begin
					plane_d = '0;
					row_d   = ROWW'(row_inc);
					if (row_inc >= ROWCW'(ru)) begin
						fin_d = FIN_DONE;
						done  = 1'b1;
					end
				end else begin
					plane_d = PLW'(plane_inc);
				end
			end else begin
				col_d = COLW'(col_sum);
			end
		end

		if (done) begin
			status = 3'(ST_COMPLETE);
		end else if (cls.last_byte && status == 3'(ST_BUSY)) begin
			status = 3'(ST_TRUNCATED);
		end

		res.write_valid = emit;
		res.byte_value  = emit ? cls.body_byte : 8'd0;
		res.run_length  = emit ? emit_cnt : 8'd0;
		res.plane_index = emit ? 3'(plane_q) : 3'd0;
		res.row_index   = emit ? 12'(row_q) : 12'd0;
		res.column_byte = emit ? 9'(col_q) : 9'd0;
		res.status      = status;

		// end of body: start over for the next one
		if (cls.last_byte) begin
			phase_d = PH_CONTROL;
			lit_d   = 8'd0;
			rep_d   = 8'd0;
			col_d   = '0;
			plane_d = '0;
			row_d   = '0;
			fin_d   = FIN_RUNNING;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_CONTROL;
			lit_q       <= 8'd0;
			rep_q       <= 8'd0;
			col_q       <= '0;
			plane_q     <= '0;
			row_q       <= '0;
			fin_q       <= FIN_RUNNING;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_d;
				lit_q   <= lit_d;
				rep_q   <= rep_d;
				col_q   <= col_d;
				plane_q <= plane_d;
				row_q   <= row_d;
				fin_q   <= fin_d;
			end
			if (cls_ready) begin
				out_valid_q <= cls_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

endmodule

// ===== hdl/planar_byterun1_row_decoder_core.sv =====
// top level of the planar byterun1 row decoder: config registers, front, queue, back
// depends on rbd_pkg, rbd_body_if, rbd_result_if, rbd_front, rbd_queue, rbd_back
//
// channel   dir   transfer when          payload
// body      in    body.valid&&ready      body_byte, last_byte
// result    out   result.valid&&ready    write_valid .. status
// cfg       in    cfg_we                 cfg_index, cfg_data
//
// one byte per cycle sustained while result is ready; the decode state loop in the back part
// updates once per taken byte. a byte passes the front register and the queue to the result register.
// the queue lets the front keep taking bytes while result stalls, until the queue is full.
// reset clears all decode state and loads the register defaults (mode 1, 320x200, 5 planes).
module planar_byterun1_row_decoder_core #(
	parameter int MAX_ROW_BYTES = rbd_pkg::DEF_MAX_ROW_BYTES,
	parameter int MAX_PLANES    = rbd_pkg::DEF_MAX_PLANES,
	parameter int MAX_ROWS      = rbd_pkg::DEF_MAX_ROWS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	rbd_body_if.sink                       body,
	rbd_result_if.source                   result,
	input  logic                           cfg_we,
	input  logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rbd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rbd_pkg::*;

	cfg_t cfg_q;
	logic cls_valid, cls_ready;
	cls_t cls_f;
	logic q_valid, q_ready;
	cls_t q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode   <= MODE_RUN1;
			cfg_q.width  <= 13'd320;
			cfg_q.height <= 13'd200;
			cfg_q.planes <= 4'd5;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MODE:   cfg_q.mode   <= cfg_data[7:0];
				REG_WIDTH:  cfg_q.width  <= cfg_data;
				REG_HEIGHT: cfg_q.height <= cfg_data;
				REG_PLANES: cfg_q.planes <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	rbd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.body      (body),
		.cls_valid (cls_valid),
		.cls       (cls_f),
		.cls_ready (cls_ready)
	);

	rbd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (cls_valid),
		.push_data  (cls_f),
		.push_ready (cls_ready),
		.pop_valid  (q_valid),
		.pop_data   (q_data),
		.pop_ready  (q_ready)
	);

	rbd_back #(
		.MAX_ROW_BYTES (MAX_ROW_BYTES),
		.MAX_PLANES    (MAX_PLANES),
		.MAX_ROWS      (MAX_ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cls_valid (q_valid),
		.cls       (q_data),
		.cls_ready (q_ready),
		.result    (result)
	);

	// a result without a write carries zeroed fields
	a_nowrite_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.data.write_valid |->
			result.data.byte_value == 8'd0 && result.data.run_length == 8'd0)
		else $error("result without write has nonzero fields");

	// a write always carries a run of 1..128
	a_run_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.write_valid |->
			result.data.run_length != 8'd0 && result.data.run_length <= 8'd128)
		else $error("write run length out of range");

	// errors and ignored bytes never write
	a_err_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.data.status == 3'(ST_IGNORED) ||
			result.data.status == 3'(ST_OVERFLOW) ||
			result.data.status == 3'(ST_BADMODE)) |-> !result.data.write_valid)
		else $error("write reported with error or ignored status");

	// completion is only reported together with a write
	a_done_write: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.status == 3'(ST_COMPLETE) |->
			result.data.write_valid)
		else $error("image complete without a write");

endmodule
